// ----- sv/sync_length_frame_deframer_defines.svh -----
// Assertion macros shared by the deframer checker
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SLFD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SLFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/slfd_pkg.sv -----
// Constants, types and parser states of the sync/length frame deframer
package slfd_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [7:0] SYNC_RESET = 8'd170;

    localparam logic STATUS_FRAME    = 1'b0;
    localparam logic STATUS_TOO_LONG = 1'b1;

    // Parser phases, one-hot
    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_TYPE  = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_DRAIN = 5'b10000
    } slfd_phase_t;

    // Access request to the payload store
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } slfd_mem_req_t;

endpackage

// ----- sv/slfd_store.sv -----
// Payload store: one write port, one registered read port
module slfd_store (
    input  logic                  aclk,
    input  slfd_pkg::slfd_mem_req_t req,
    output logic [7:0]            rd_data
);

    logic [7:0] mem [slfd_pkg::STORE_DEPTH];

    // Write the incoming payload byte
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Registered read; hold the last word otherwise
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- sv/sync_length_frame_deframer.sv -----
// Sync/type/length frame deframer: hunts for the sync byte held in the configuration
// register, takes a type byte and a length byte, then stores that many payload bytes.
// While parsing, one received byte is accepted per cycle while no result or pending
// read waits on the sink. A zero length gives one result at once, and a length above
// 64 gives one error result; both return to the hunt. A frame of N payload bytes is
// drained from the store as N results, one per cycle when the sink keeps ready high.
// After the last payload byte is taken, the block enters the drain phase, reads each
// byte through the store's registered read port and loads it into the output register.
// No input is accepted until the last result of the run has been taken. The store has
// no reset or clearing pass; every byte read was written earlier in the same frame.
module sync_length_frame_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // received bytes
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // results
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_status,
    output logic [7:0] m_frame_type,
    output logic [7:0] m_frame_length,
    output logic       m_has_data,
    output logic [7:0] m_data_byte,
    output logic [5:0] m_data_index,
    output logic       m_last
);

    localparam int AW = slfd_pkg::ADDR_W;
    localparam int LW = slfd_pkg::LEN_W;

    slfd_pkg::slfd_phase_t phase_reg, phase_next;
    logic [7:0]    sync_reg;
    logic [7:0]    held_type_reg, held_type_next;
    logic [LW-1:0] held_length_reg, held_length_next;
    logic [LW-1:0] bytes_taken_reg, bytes_taken_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [AW-1:0] rd_idx_q_reg, rd_idx_q_next;
    logic          rd_last_reg, rd_last_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_status_reg, m_status_next;
    logic [7:0] m_type_reg, m_type_next;
    logic [7:0] m_length_reg, m_length_next;
    logic       m_has_data_reg, m_has_data_next;
    logic [7:0] m_data_reg, m_data_next;
    logic [5:0] m_index_reg, m_index_next;
    logic       m_last_reg, m_last_next;

    slfd_pkg::slfd_mem_req_t mem_req;
    logic [7:0]    rd_data;
    logic          out_free;
    logic          in_acc;
    logic [LW-1:0] taken_inc;
    logic [LW-1:0] rd_idx_inc;

    slfd_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign cfg_ready  = 1'b1;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (phase_reg != slfd_pkg::PH_DRAIN) && !rd_pend_reg && out_free;
    assign in_acc     = s_valid && s_ready;
    assign taken_inc  = bytes_taken_reg + LW'(1);
    assign rd_idx_inc = LW'(rd_idx_reg) + LW'(1);

    // Parser, store access and output register
    always_comb begin
        phase_next       = phase_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        bytes_taken_next = bytes_taken_reg;
        rd_idx_next      = rd_idx_reg;
        rd_pend_next     = rd_pend_reg;
        rd_idx_q_next    = rd_idx_q_reg;
        rd_last_next     = rd_last_reg;

        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_type_next      = m_type_reg;
        m_length_next    = m_length_reg;
        m_has_data_next  = m_has_data_reg;
        m_data_next      = m_data_reg;
        m_index_next     = m_index_reg;
        m_last_next      = m_last_reg;

        mem_req.wr_en    = 1'b0;
        mem_req.wr_addr  = bytes_taken_reg[AW-1:0];
        mem_req.wr_data  = s_rx_byte;
        mem_req.rd_en    = 1'b0;
        mem_req.rd_addr  = rd_idx_reg;

        // Drop the transaction taken by the sink
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Advance read data into the output register
        if (rd_pend_reg && out_free) begin
            m_valid_next    = 1'b1;
            m_status_next   = slfd_pkg::STATUS_FRAME;
            m_type_next     = held_type_reg;
            m_length_next   = 8'(held_length_reg);
            m_has_data_next = 1'b1;
            m_data_next     = rd_data;
            m_index_next    = 6'(rd_idx_q_reg);
            m_last_next     = rd_last_reg;
            rd_pend_next    = 1'b0;
        end

        case (phase_reg)
            slfd_pkg::PH_HUNT: begin
                if (in_acc && (s_rx_byte == sync_reg)) begin
                    phase_next = slfd_pkg::PH_TYPE;
                end
            end
            slfd_pkg::PH_TYPE: begin
                if (in_acc) begin
                    held_type_next = s_rx_byte;
                    phase_next     = slfd_pkg::PH_LEN;
                end
            end
            slfd_pkg::PH_LEN: begin
                if (in_acc) begin
                    if (s_rx_byte == 8'd0) begin
                        // empty frame: a single result, no payload
                        m_valid_next    = 1'b1;
                        m_status_next   = slfd_pkg::STATUS_FRAME;
                        m_type_next     = held_type_reg;
                        m_length_next   = 8'd0;
                        m_has_data_next = 1'b0;
                        m_data_next     = 8'd0;
                        m_index_next    = 6'd0;
                        m_last_next     = 1'b1;
                        phase_next      = slfd_pkg::PH_HUNT;
                    end else if (s_rx_byte > 8'(slfd_pkg::MAX_PAYLOAD)) begin
                        // declared length does not fit: report and rehunt
                        m_valid_next    = 1'b1;
                        m_status_next   = slfd_pkg::STATUS_TOO_LONG;
                        m_type_next     = held_type_reg;
                        m_length_next   = s_rx_byte;
                        m_has_data_next = 1'b0;
                        m_data_next     = 8'd0;
                        m_index_next    = 6'd0;
                        m_last_next     = 1'b1;
                        phase_next      = slfd_pkg::PH_HUNT;
                    end else begin
                        held_length_next = s_rx_byte[LW-1:0];
                        bytes_taken_next = '0;
                        phase_next       = slfd_pkg::PH_DATA;
                    end
                end
            end
            slfd_pkg::PH_DATA: begin
                if (in_acc) begin
                    mem_req.wr_en    = 1'b1;
                    bytes_taken_next = taken_inc;
                    if (taken_inc >= held_length_reg) begin
                        rd_idx_next = '0;
                        phase_next  = slfd_pkg::PH_DRAIN;
                    end
                end
            end
            slfd_pkg::PH_DRAIN: begin
                // Issue the next read when the read stage can move on
                if (!rd_pend_reg || out_free) begin
                    mem_req.rd_en = 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_idx_q_next = rd_idx_reg;
                    rd_last_next  = (rd_idx_inc == held_length_reg);
                    rd_idx_next   = rd_idx_reg + AW'(1);
                    if (rd_idx_inc == held_length_reg) begin
                        phase_next = slfd_pkg::PH_HUNT;
                    end
                end
            end
            default: begin
                phase_next = slfd_pkg::PH_HUNT;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= slfd_pkg::PH_HUNT;
            sync_reg        <= slfd_pkg::SYNC_RESET;
            held_type_reg   <= 8'd0;
            held_length_reg <= '0;
            bytes_taken_reg <= '0;
            rd_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            held_type_reg   <= held_type_next;
            held_length_reg <= held_length_next;
            bytes_taken_reg <= bytes_taken_next;
            rd_pend_reg     <= rd_pend_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                sync_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        rd_idx_q_reg   <= rd_idx_q_next;
        rd_last_reg    <= rd_last_next;
        m_status_reg   <= m_status_next;
        m_type_reg     <= m_type_next;
        m_length_reg   <= m_length_next;
        m_has_data_reg <= m_has_data_next;
        m_data_reg     <= m_data_next;
        m_index_reg    <= m_index_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_frame_type   = m_type_reg;
    assign m_frame_length = m_length_reg;
    assign m_has_data     = m_has_data_reg;
    assign m_data_byte    = m_data_reg;
    assign m_data_index   = m_index_reg;
    assign m_last         = m_last_reg;

endmodule

// ----- sv/slfd_checker.sv -----
// Port-level checker for the deframer, bound to the top level
`include "sync_length_frame_deframer_defines.svh"

module slfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_has_data,
    input logic [7:0] m_data_byte,
    input logic [5:0] m_data_index,
    input logic       m_last
);

    // A stalled result holds its payload
    `SLFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data_byte) && $stable(m_data_index) && $stable(m_last), "stalled result changed")

    // A result without payload is a single, zeroed one
    `SLFD_ASSERT_IMPL(a_no_data_single, aclk, aresetn, m_valid && !m_has_data, m_last && (m_data_byte == 8'd0) && (m_data_index == 6'd0), "empty result not single or not zeroed")

    // No input is taken while a run is still being emitted
    `SLFD_ASSERT_IMPL(a_run_blocks_input, aclk, aresetn, m_valid && !m_last, !s_ready, "input accepted during a run")

    // A taken payload result is followed at once by the next index
    `SLFD_ASSERT_NEXT(a_run_order, aclk, aresetn, m_valid && m_ready && m_has_data && !m_last, m_valid && m_has_data && (m_data_index == 6'($past(m_data_index) + 6'd1)), "payload run out of order")

endmodule

bind sync_length_frame_deframer slfd_checker u_slfd_checker (.*);
